// ===== rtl/core/wrd_pkg.sv =====
package wrd_pkg;

    localparam int HEAD_DEPTH  = 5;
    localparam int COUNT_W     = 5;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

    localparam logic [2:0] ST_TOUCH    = 3'd0;
    localparam logic [2:0] ST_PENS     = 3'd1;
    localparam logic [2:0] ST_ACK      = 3'd2;
    localparam logic [2:0] ST_IGNORED  = 3'd3;
    localparam logic [2:0] ST_UNKNOWN  = 3'd4;
    localparam logic [2:0] ST_BAD_SIZE = 3'd5;
    localparam logic [2:0] ST_BAD_SUM  = 3'd6;

    localparam logic [7:0] MAJOR_TOUCH = 8'h01;
    localparam logic [7:0] MAJOR_PANEL = 8'h02;
    localparam logic [7:0] MINOR_ACK   = 8'hc3;
    localparam logic [7:0] MINOR_TRAY  = 8'hd2;
    localparam logic [7:0] SUB_PENS    = 8'h05;
    localparam logic [7:0] SUB_IGNORED = 8'h06;

    typedef struct packed {
        logic [HEAD_DEPTH-1:0][7:0] head;
        logic [COUNT_W-1:0]         size;
        logic                       xor_zero;
        logic                       too_long;
    } record_t;

endpackage

// ===== rtl/core/wrd_if.sv =====
interface wrd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       end_of_report;

    modport source (output valid, output rx_byte, output end_of_report, input ready);
    modport sink   (input valid, input rx_byte, input end_of_report, output ready);
endinterface

interface wrd_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic        touch_down;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [4:0]  pen_bits;
    logic        tool_finger;
    logic        tool_pen;
    logic        tool_rubber;

    modport source (
        output valid, output status, output touch_down, output pos_x, output pos_y,
        output pen_bits, output tool_finger, output tool_pen, output tool_rubber,
        input ready
    );
    modport sink (
        input valid, input status, input touch_down, input pos_x, input pos_y,
        input pen_bits, input tool_finger, input tool_pen, input tool_rubber,
        output ready
    );
endinterface

// ===== rtl/core/whiteboard_report_decoder.sv =====
// Whiteboard report decoder: takes one report byte per clock on rx (end_of_report on the
// final byte) and gives one decoded result on report per report, registered first in the
// queue and then in the output register. Bytes are taken every cycle; rx stalls only when
// the two-entry queue between the byte front end and the decode stage is full, which
// happens only while report is held off. Reports longer than MAX_REPORT_BYTES give bad size.
module whiteboard_report_decoder #(
    parameter int MAX_REPORT_BYTES = 18
) (
    input  logic      clk,
    input  logic      rst_n,
    wrd_in_if.sink    rx,
    wrd_out_if.source report
);

    wrd_pkg::record_t push_rec;
    wrd_pkg::record_t head_rec;
    logic             push;
    logic             pop;
    logic             full;
    logic             empty;

    wrd_front #(
        .MAX_REPORT_BYTES(MAX_REPORT_BYTES)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .full  (full),
        .push  (push),
        .rec   (push_rec)
    );

    wrd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .full     (full),
        .empty    (empty),
        .head_rec (head_rec)
    );

    wrd_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .empty  (empty),
        .rec    (head_rec),
        .pop    (pop),
        .report (report)
    );

endmodule

// ===== rtl/core/wrd_front.sv =====
module wrd_front #(
    parameter int MAX_REPORT_BYTES = 18
) (
    input  logic             clk,
    input  logic             rst_n,
    wrd_in_if.sink           rx,
    input  logic             full,
    output logic             push,
    output wrd_pkg::record_t rec
);

    logic [wrd_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [7:0]                  xor_reg, xor_next;
    logic                        too_long_reg, too_long_next;
    logic [7:0]                  head_reg [wrd_pkg::HEAD_DEPTH];
    logic                        accept;

    assign rx.ready = !full;
    assign accept   = rx.valid && rx.ready;
    assign push     = accept && rx.end_of_report;

    always_comb
    begin
        count_next    = (count_reg < wrd_pkg::COUNT_MAX) ? count_reg + 5'd1 : count_reg;
        xor_next      = (count_reg != '0) ? (xor_reg ^ rx.rx_byte) : xor_reg;
        too_long_next = too_long_reg || (count_next > 5'(MAX_REPORT_BYTES));
    end

    // current byte merged into the captured head
    always_comb
    begin
        for (int i = 0; i < wrd_pkg::HEAD_DEPTH; i++)
        begin
            rec.head[i] = (count_reg == 5'(i)) ? rx.rx_byte : head_reg[i];
        end
        rec.size     = count_next;
        rec.xor_zero = (xor_next == 8'h00);
        rec.too_long = too_long_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            xor_reg      <= '0;
            too_long_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (rx.end_of_report)
            begin
                count_reg    <= '0;
                xor_reg      <= '0;
                too_long_reg <= 1'b0;
            end
            else
            begin
                count_reg    <= count_next;
                xor_reg      <= xor_next;
                too_long_reg <= too_long_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < wrd_pkg::HEAD_DEPTH; i++)
        begin
            if (accept && count_reg == 5'(i))
            begin
                head_reg[i] <= rx.rx_byte;
            end
        end
    end

    a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (count_reg == '0 && xor_reg == '0 && !too_long_reg))
        else $error("report state not cleared after final beat");

    a_too_long_count: assert property (@(posedge clk) disable iff (!rst_n)
        too_long_reg |-> (count_reg > 5'(MAX_REPORT_BYTES)))
        else $error("overlong flag set below limit");

    a_xor_first: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (xor_reg == '0))
        else $error("checksum nonzero at start of report");

endmodule

// ===== rtl/core/wrd_queue.sv =====
module wrd_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  wrd_pkg::record_t push_rec,
    input  logic             pop,
    output logic             full,
    output logic             empty,
    output wrd_pkg::record_t head_rec
);

    localparam int PTR_W = $clog2(wrd_pkg::QUEUE_DEPTH);

    wrd_pkg::record_t   slot_reg [wrd_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]     fill_reg, fill_next;

    assign full     = (fill_reg == (PTR_W+1)'(wrd_pkg::QUEUE_DEPTH));
    assign empty    = (fill_reg == '0);
    assign head_rec = slot_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(wrd_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(wrd_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_rec;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= (PTR_W+1)'(wrd_pkg::QUEUE_DEPTH))
        else $error("queue fill out of range");

endmodule

// ===== rtl/core/wrd_back.sv =====
module wrd_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             empty,
    input  wrd_pkg::record_t rec,
    output logic             pop,
    wrd_out_if.source        report
);

    logic        valid_reg;
    logic [2:0]  status_reg, status_next;
    logic        down_reg, down_next;
    logic [11:0] x_reg, x_next;
    logic [11:0] y_reg, y_next;
    logic [4:0]  pens_reg, pens_next;
    logic        finger_reg, finger_next;
    logic        pen_reg, pen_next;
    logic        rubber_reg, rubber_next;
    logic [7:0]  h0, h1, h2, h3, h4;

    assign pop = !empty && (!valid_reg || report.ready);

    assign h0 = rec.head[0];
    assign h1 = rec.head[1];
    assign h2 = rec.head[2];
    assign h3 = rec.head[3];
    assign h4 = rec.head[4];

    always_comb
    begin
        status_next = wrd_pkg::ST_UNKNOWN;
        down_next   = 1'b0;
        x_next      = '0;
        y_next      = '0;
        pens_next   = '0;
        finger_next = 1'b0;
        pen_next    = 1'b0;
        rubber_next = 1'b0;
        if (rec.too_long)
        begin
            status_next = wrd_pkg::ST_BAD_SIZE;
        end
        else if (h0 == wrd_pkg::MAJOR_TOUCH)
        begin
            if (rec.size < 5'd5)
            begin
                status_next = wrd_pkg::ST_BAD_SIZE;
            end
            else
            begin
                status_next = wrd_pkg::ST_TOUCH;
                down_next   = h1[0];
                x_next      = {h3[3:0], h2};
                y_next      = {h4, h3[7:4]};
            end
        end
        else if (h0 == wrd_pkg::MAJOR_PANEL)
        begin
            if (!rec.xor_zero)
            begin
                status_next = wrd_pkg::ST_BAD_SUM;
            end
            else if (rec.size < 5'd2)
            begin
                status_next = wrd_pkg::ST_BAD_SIZE;
            end
            else if (h1 == wrd_pkg::MINOR_ACK)
            begin
                status_next = wrd_pkg::ST_ACK;
            end
            else if (h1 != wrd_pkg::MINOR_TRAY)
            begin
                status_next = wrd_pkg::ST_UNKNOWN;
            end
            else if (rec.size < 5'd3)
            begin
                status_next = wrd_pkg::ST_BAD_SIZE;
            end
            else if (h2 == wrd_pkg::SUB_PENS)
            begin
                if (rec.size < 5'd4)
                begin
                    status_next = wrd_pkg::ST_BAD_SIZE;
                end
                else
                begin
                    status_next = wrd_pkg::ST_PENS;
                    pens_next   = h3[4:0];
                    finger_next = (h3[4:0] == 5'd0);
                    pen_next    = (h3[4:0] != 5'd0) && !h3[2];
                    rubber_next = h3[2];
                end
            end
            else if (h2 == wrd_pkg::SUB_IGNORED)
            begin
                status_next = wrd_pkg::ST_IGNORED;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (report.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            status_reg <= status_next;
            down_reg   <= down_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
            pens_reg   <= pens_next;
            finger_reg <= finger_next;
            pen_reg    <= pen_next;
            rubber_reg <= rubber_next;
        end
    end

    assign report.valid       = valid_reg;
    assign report.status      = status_reg;
    assign report.touch_down  = down_reg;
    assign report.pos_x       = x_reg;
    assign report.pos_y       = y_reg;
    assign report.pen_bits    = pens_reg;
    assign report.tool_finger = finger_reg;
    assign report.tool_pen    = pen_reg;
    assign report.tool_rubber = rubber_reg;

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (status_reg != 3'd7))
        else $error("reserved status code driven");

    a_tool_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> $onehot0({finger_reg, pen_reg, rubber_reg}))
        else $error("more than one tool flagged");

    a_pop_loads: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> valid_reg)
        else $error("popped record not presented");

endmodule
